FILE: hdl/rvt_pkg.sv
// ----------------------------------------------------------------------------
// rvt_pkg
// Shared types and constants for the range value table.
// ----------------------------------------------------------------------------
package rvt_pkg;

  localparam int MAX_BREAKPOINTS_DEF = 64;
  localparam int KEY_BITS            = 32;
  localparam int VALUE_BITS          = 8;
  localparam int COUNT_BITS          = 7;

  localparam logic MODE_ASSIGN = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  typedef struct packed {
    logic                  mode;
    logic [KEY_BITS-1:0]   key_begin;
    logic [KEY_BITS-1:0]   key_end;
    logic [VALUE_BITS-1:0] new_value;
  } in_word_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] read_value;
    logic                  overflow;
    logic [COUNT_BITS-1:0] entry_count;
  } out_word_t;

endpackage

FILE: hdl/rvt_ram.sv
// ----------------------------------------------------------------------------
// rvt_ram
// Generic simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module rvt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

FILE: hdl/range_value_table_unit.sv
// Operation: lookup and assign scan the used entries, one per cycle (an assign with an
// empty range skips this); an assign that fits then shifts the tail entries one per cycle
// and writes up to two new ones. One word is in flight at a time; the next word is
// taken once the current one's result is registered at the output.
// Reset: synchronous; clears the entry count, default value and output valid. No
// clearing pass: only entries below the count are ever read.
// ----------------------------------------------------------------------------
// range_value_table_unit
// Sorted breakpoint table with range assign and point lookup, held in one RAM.
// ----------------------------------------------------------------------------
module range_value_table_unit
  import rvt_pkg::*;
#(
  parameter int MAX_BREAKPOINTS = MAX_BREAKPOINTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_word,
  input  logic                  cfg_wr_en,
  input  logic [VALUE_BITS-1:0] cfg_wr_data
);

  localparam int AW = $clog2(MAX_BREAKPOINTS);
  localparam int CW = $clog2(MAX_BREAKPOINTS + 1);
  localparam int XW = CW + 2;
  localparam int DW = KEY_BITS + VALUE_BITS;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_SCAN = 7'b0000010,
    S_CALC = 7'b0000100,
    S_MOVE = 7'b0001000,
    S_INS1 = 7'b0010000,
    S_INS2 = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t                state;
  logic [VALUE_BITS-1:0] dflt;
  logic [CW-1:0]         used;
  logic                  mode;
  logic [KEY_BITS-1:0]   kb, ke;
  logic [VALUE_BITS-1:0] nv, prev_val, after;
  logic [CW-1:0]         lo, hi, left, dmag;
  logic [AW-1:0]         idx, dst;
  logic                  pend, grow, ins_a, ins_b;
  logic [XW-1:0]         n_new;
  out_word_t             res;

  logic                  wr_en, rd_en;
  logic [AW-1:0]         wr_addr;
  logic [DW-1:0]         wr_data, rd_data;
  logic [KEY_BITS-1:0]   rk;
  logic [VALUE_BITS-1:0] rv;

  // CALC arithmetic
  logic                  c_ia, c_ib;
  logic [CW-1:0]         span, ins_cnt;
  logic [XW-1:0]         c_n;

  assign rk = rd_data[DW-1:VALUE_BITS];
  assign rv = rd_data[VALUE_BITS-1:0];
  assign in_ready = (state == S_IDLE);

  always_comb begin
    c_ia    = (nv != prev_val);
    c_ib    = (after != nv);
    span    = hi - lo;
    ins_cnt = CW'(c_ia) + CW'(c_ib);
    c_n     = XW'(used) + XW'(ins_cnt) - XW'(span);
  end

  always_comb begin
    rd_en   = 1'b0;
    wr_en   = 1'b0;
    wr_addr = dst;
    wr_data = rd_data;
    unique case (state)
      S_SCAN: rd_en = (left != '0);
      S_MOVE: begin
        rd_en = (left != '0);
        wr_en = pend;
      end
      S_INS1: begin
        wr_en   = ins_a;
        wr_addr = lo[AW-1:0];
        wr_data = {kb, nv};
      end
      S_INS2: begin
        wr_en   = ins_b;
        wr_addr = AW'(lo + CW'(ins_a));
        wr_data = {ke, after};
      end
      default: ;
    endcase
  end

  rvt_ram #(.WIDTH(DW), .DEPTH(MAX_BREAKPOINTS)) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(idx),
    .rd_data(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      used      <= '0;
      dflt      <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        dflt <= cfg_wr_data;
      end
      // DONE reloads the output itself
      if (out_valid && out_ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            mode     <= in_word.mode;
            kb       <= in_word.key_begin;
            ke       <= (in_word.mode == MODE_LOOKUP) ? in_word.key_begin : in_word.key_end;
            nv       <= in_word.new_value;
            lo       <= '0;
            hi       <= '0;
            prev_val <= dflt;
            after    <= dflt;
            idx      <= '0;
            left     <= used;
            pend     <= 1'b0;
            res      <= '{read_value: '0, overflow: 1'b0,
                          entry_count: COUNT_BITS'(used)};
            if (in_word.mode == MODE_ASSIGN &&
                !($signed(in_word.key_begin) < $signed(in_word.key_end))) begin
              state <= S_DONE;  // empty range
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          pend <= (left != '0);
          if (left != '0) begin
            idx  <= idx + AW'(1);
            left <= left - CW'(1);
          end
          if (pend) begin
            if ($signed(rk) < $signed(kb)) begin
              lo       <= lo + CW'(1);
              prev_val <= rv;
            end
            if ($signed(rk) <= $signed(ke)) begin
              hi    <= hi + CW'(1);
              after <= rv;
            end
          end
          if (left == '0 && !pend) begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          ins_a <= c_ia;
          ins_b <= c_ib;
          n_new <= c_n;
          grow  <= (ins_cnt > span);
          dmag  <= (ins_cnt > span) ? ins_cnt - span : span - ins_cnt;
          left  <= (ins_cnt != span) ? used - hi : '0;
          idx   <= (ins_cnt > span) ? AW'(used - CW'(1)) : hi[AW-1:0];
          pend  <= 1'b0;
          if (mode == MODE_LOOKUP) begin
            res.read_value <= after;
            state          <= S_DONE;
          end else if (c_n > XW'(MAX_BREAKPOINTS)) begin
            res.overflow <= 1'b1;
            state        <= S_DONE;
          end else begin
            state <= S_MOVE;
          end
        end
        S_MOVE: begin
          // grow: walk down from the top; shrink: walk up from hi
          pend <= (left != '0);
          if (left != '0) begin
            idx  <= grow ? idx - AW'(1) : idx + AW'(1);
            left <= left - CW'(1);
            dst  <= grow ? AW'(XW'(idx) + XW'(dmag)) : AW'(XW'(idx) - XW'(dmag));
          end
          if (left == '0 && !pend) begin
            state <= S_INS1;
          end
        end
        S_INS1: state <= S_INS2;
        S_INS2: begin
          used            <= CW'(n_new);
          res.entry_count <= COUNT_BITS'(n_new);
          state           <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
            out_word  <= res;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
